// ===== src/tpsa_pkg.sv =====
// tpsa_pkg: shared types and constants of the two-pool slot allocator
// status codes, request and pool codes, field widths, register indexes, register reset values and default pool geometry
// no dependencies
package tpsa_pkg;

	// default pool geometry (slot sizes are powers of two)
	localparam int SMALL_SLOTS_DEF      = 20;
	localparam int LARGE_SLOTS_DEF      = 4;
	localparam int SMALL_SLOT_BYTES_DEF = 4096;
	localparam int LARGE_SLOT_BYTES_DEF = 65536;

	// field widths
	localparam int ADDR_W   = 32;
	localparam int INDEX_W  = 5;
	localparam int CFG_IDX_W = 1;
	localparam int S_TDATA_W = 32;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int M_TUSER_W = 3;

	// register reset values
	localparam logic [ADDR_W-1:0] SMALL_BASE_RST = 32'h0000_0000;
	localparam logic [ADDR_W-1:0] LARGE_BASE_RST = 32'h0010_0000;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_BASE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_BASE = 1'b1;

	// request codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// pool codes
	localparam logic POOL_SMALL = 1'b0;
	localparam logic POOL_LARGE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOMEM    = 2'd1,
		ST_BADPARAM = 2'd2,
		ST_BADMEM   = 2'd3
	} status_t;

endpackage

// ===== src/two_pool_slot_allocator.sv =====
// two_pool_slot_allocator: top level, two fixed-size slot pools with in-use bitmaps
// depends on tpsa_pkg
//
// usage
//   requests enter on the s_axis channel, one beat per request:
//     alloc (opcode 0) takes the lowest free slot of the pool named by pool_select
//     free (opcode 1) returns the slot whose byte address is free_address
//   every request gives exactly one result beat on the m_axis channel: status,
//   slot address, slot index and pool; all but status are zero on an error
//   the user writes pool bases through cfg_we / cfg_index / cfg_data only while idle; no check enforces it
// pipeline and throughput
//   a request is registered (stage s1), handled there by a priority
//   encoder, range compares and a shift-and-add, then lands in the result
//   register, which drives the result beat on m_axis
//   one request per cycle sustained while m_axis_tready is high; the bitmap
//   update of one request is seen by the request right behind it, since both happen in stage s1
// reset
//   arst_n clears both bitmaps (all slots free), restores the pool bases and
//   empties both stages; no clearing pass is needed
// stall
//   while m_axis_tready is low the result register holds; s1 holds behind it,
//   and s_axis_tready drops only once both are full
module two_pool_slot_allocator #(
	parameter int SMALL_SLOTS      = tpsa_pkg::SMALL_SLOTS_DEF,
	parameter int LARGE_SLOTS      = tpsa_pkg::LARGE_SLOTS_DEF,
	parameter int SMALL_SLOT_BYTES = tpsa_pkg::SMALL_SLOT_BYTES_DEF,
	parameter int LARGE_SLOT_BYTES = tpsa_pkg::LARGE_SLOT_BYTES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [tpsa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpsa_pkg::ADDR_W-1:0]         cfg_data,
	// request channel
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [tpsa_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // free_address[31:0]
	input  logic [tpsa_pkg::S_TUSER_W-1:0]      s_axis_tuser,  // opcode[0], pool_select[1]
	// result channel
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [tpsa_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // slot_address[31:0], slot_index[36:32], zero[39:37]
	output logic [tpsa_pkg::M_TUSER_W-1:0]      m_axis_tuser   // status[1:0], slot_pool[2]
);

	localparam int AW = tpsa_pkg::ADDR_W;
	localparam int SMALL_SHIFT = $clog2(SMALL_SLOT_BYTES);
	localparam int LARGE_SHIFT = $clog2(LARGE_SLOT_BYTES);
	localparam int MAX_SLOTS = (SMALL_SLOTS > LARGE_SLOTS) ? SMALL_SLOTS : LARGE_SLOTS;
	localparam int IDX_RAW_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	// internal index is at least as wide as the result field
	localparam int IDX_W = (IDX_RAW_W > tpsa_pkg::INDEX_W) ? IDX_RAW_W : tpsa_pkg::INDEX_W;
	// distance from base to last slot, computed in 33 bits so the end never wraps
	localparam logic [AW:0] SMALL_SPAN = (AW+1)'((SMALL_SLOTS - 1) * SMALL_SLOT_BYTES);
	localparam logic [AW:0] LARGE_SPAN = (AW+1)'((LARGE_SLOTS - 1) * LARGE_SLOT_BYTES);

	// configuration
	logic [AW-1:0] small_base_q;
	logic [AW-1:0] large_base_q;

	// in-use bitmaps
	logic [SMALL_SLOTS-1:0] small_in_use_q;
	logic [LARGE_SLOTS-1:0] large_in_use_q;
	logic [SMALL_SLOTS-1:0] small_in_use_d;
	logic [LARGE_SLOTS-1:0] large_in_use_d;

	// stage s1: registered request
	logic          valid_s1;
	logic          op_s1;
	logic          pool_s1;
	logic [AW-1:0] addr_s1;

	// result register
	logic                  out_valid_q;
	tpsa_pkg::status_t     out_status_q;
	logic [AW-1:0]         out_addr_q;
	logic [IDX_W-1:0]      out_index_q;
	logic                  out_pool_q;

	// handshake
	logic out_load;
	logic fire_s1;

	// stage s1 results
	tpsa_pkg::status_t res_status;
	logic [AW-1:0]     res_addr;
	logic [IDX_W-1:0]  res_index;
	logic              res_pool;

	// allocate path
	logic             small_found;
	logic             large_found;
	logic [IDX_W-1:0] small_free_idx;
	logic [IDX_W-1:0] large_free_idx;
	logic             alloc_found;
	logic [IDX_W-1:0] alloc_idx;
	logic [AW-1:0]    alloc_addr;

	// free path
	logic [AW:0]      small_end;
	logic [AW:0]      large_end;
	logic             in_small;
	logic             in_large;
	logic [AW-1:0]    free_off;
	logic             free_aligned;
	logic [IDX_W-1:0] free_idx;

	logic alloc_ok;
	logic free_ok;

	assign out_load      = !out_valid_q || m_axis_tready;
	assign fire_s1       = valid_s1 && out_load;
	assign s_axis_tready = !valid_s1 || out_load;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_base_q <= tpsa_pkg::SMALL_BASE_RST;
			large_base_q <= tpsa_pkg::LARGE_BASE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tpsa_pkg::REG_SMALL_BASE: small_base_q <= cfg_data;
				tpsa_pkg::REG_LARGE_BASE: large_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage s1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// stage s1 payload
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= s_axis_tuser[0];
			pool_s1 <= s_axis_tuser[1];
			addr_s1 <= s_axis_tdata;
		end
	end

	// lowest free slot of each pool
	always_comb begin
		small_found    = 1'b0;
		small_free_idx = '0;
		for (int i = SMALL_SLOTS - 1; i >= 0; i--) begin
			if (!small_in_use_q[i]) begin
				small_found    = 1'b1;
				small_free_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		large_found    = 1'b0;
		large_free_idx = '0;
		for (int i = LARGE_SLOTS - 1; i >= 0; i--) begin
			if (!large_in_use_q[i]) begin
				large_found    = 1'b1;
				large_free_idx = IDX_W'(i);
			end
		end
	end

	// allocate: base plus index shifted by slot size, modulo 2^32
	always_comb begin
		if (pool_s1 == tpsa_pkg::POOL_LARGE) begin
			alloc_found = large_found;
			alloc_idx   = large_free_idx;
			alloc_addr  = large_base_q + (AW'(large_free_idx) << LARGE_SHIFT);
		end else begin
			alloc_found = small_found;
			alloc_idx   = small_free_idx;
			alloc_addr  = small_base_q + (AW'(small_free_idx) << SMALL_SHIFT);
		end
	end

	// free: range check, small pool wins on overlap, then alignment
	assign small_end = {1'b0, small_base_q} + SMALL_SPAN;
	assign large_end = {1'b0, large_base_q} + LARGE_SPAN;
	assign in_small  = (addr_s1 >= small_base_q) && ({1'b0, addr_s1} <= small_end);
	assign in_large  = (addr_s1 >= large_base_q) && ({1'b0, addr_s1} <= large_end);

	always_comb begin
		if (in_small) begin
			free_off     = addr_s1 - small_base_q;
			free_aligned = (free_off[SMALL_SHIFT-1:0] == '0);
			free_idx     = IDX_W'(free_off >> SMALL_SHIFT);
		end else begin
			free_off     = addr_s1 - large_base_q;
			free_aligned = (free_off[LARGE_SHIFT-1:0] == '0);
			free_idx     = IDX_W'(free_off >> LARGE_SHIFT);
		end
	end

	// result selection
	always_comb begin
		alloc_ok   = 1'b0;
		free_ok    = 1'b0;
		res_status = tpsa_pkg::ST_OK;
		res_addr   = '0;
		res_index  = '0;
		res_pool   = tpsa_pkg::POOL_SMALL;
		if (op_s1 == tpsa_pkg::OP_ALLOC) begin
			if (alloc_found) begin
				alloc_ok  = 1'b1;
				res_addr  = alloc_addr;
				res_index = alloc_idx;
				res_pool  = pool_s1;
			end else begin
				res_status = tpsa_pkg::ST_NOMEM;
			end
		end else begin
			if (addr_s1 == '0 || (!in_small && !in_large)) begin
				res_status = tpsa_pkg::ST_BADPARAM;
			end else if (!free_aligned) begin
				res_status = tpsa_pkg::ST_BADMEM;
			end else begin
				free_ok   = 1'b1;
				res_addr  = addr_s1;
				res_index = free_idx;
				res_pool  = in_small ? tpsa_pkg::POOL_SMALL : tpsa_pkg::POOL_LARGE;
			end
		end
	end

	// bitmap next state
	always_comb begin
		small_in_use_d = small_in_use_q;
		for (int i = 0; i < SMALL_SLOTS; i++) begin
			if (alloc_ok && pool_s1 == tpsa_pkg::POOL_SMALL && alloc_idx == IDX_W'(i)) begin
				small_in_use_d[i] = 1'b1;
			end
			if (free_ok && in_small && free_idx == IDX_W'(i)) begin
				small_in_use_d[i] = 1'b0;
			end
		end
	end

	always_comb begin
		large_in_use_d = large_in_use_q;
		for (int i = 0; i < LARGE_SLOTS; i++) begin
			if (alloc_ok && pool_s1 == tpsa_pkg::POOL_LARGE && alloc_idx == IDX_W'(i)) begin
				large_in_use_d[i] = 1'b1;
			end
			if (free_ok && !in_small && free_idx == IDX_W'(i)) begin
				large_in_use_d[i] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			small_in_use_q <= '0;
			large_in_use_q <= '0;
		end else if (fire_s1) begin
			small_in_use_q <= small_in_use_d;
			large_in_use_q <= large_in_use_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_status_q <= res_status;
			out_addr_q   <= res_addr;
			out_index_q  <= res_index;
			out_pool_q   <= res_pool;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {
		(tpsa_pkg::M_TDATA_W - AW - tpsa_pkg::INDEX_W)'(0),
		out_index_q[tpsa_pkg::INDEX_W-1:0],
		out_addr_q
	};
	assign m_axis_tuser  = {out_pool_q, out_status_q};

`ifndef SYNTHESIS
	// error beats carry no slot
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != tpsa_pkg::ST_OK) |->
		(out_addr_q == '0 && out_index_q == '0 && out_pool_q == tpsa_pkg::POOL_SMALL))
		else $error("error result carries a nonzero slot");

	// a successful small allocation marks exactly one more slot in use
	a_small_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && alloc_ok && pool_s1 == tpsa_pkg::POOL_SMALL) |=>
		($countones(small_in_use_q) == $past($countones(small_in_use_q)) + 1))
		else $error("small allocation did not mark one slot");

	// a successful large allocation marks exactly one more slot in use
	a_large_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && alloc_ok && pool_s1 == tpsa_pkg::POOL_LARGE) |=>
		($countones(large_in_use_q) == $past($countones(large_in_use_q)) + 1))
		else $error("large allocation did not mark one slot");

	// out of memory only when the named pool is full
	a_nomem_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && op_s1 == tpsa_pkg::OP_ALLOC && res_status == tpsa_pkg::ST_NOMEM) |->
		((pool_s1 == tpsa_pkg::POOL_SMALL && (&small_in_use_q)) ||
		 (pool_s1 == tpsa_pkg::POOL_LARGE && (&large_in_use_q))))
		else $error("out of memory with a free slot");

	// a request held in s1 behind a stalled result is not lost
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_load) |=> (valid_s1 && $stable(addr_s1) && $stable(op_s1)))
		else $error("stalled request dropped from s1");
`endif

endmodule

// ===== tb/sv/two_pool_slot_allocator_checker.sv =====
`timescale 1ns / 1ps
// two_pool_slot_allocator_checker: watches the register port and both stream channels,
// predicts every result beat from its own pool bitmaps and bases, compares in order
// depends on tpsa_pkg
module two_pool_slot_allocator_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tpsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tpsa_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [tpsa_pkg::S_TDATA_W-1:0] s_axis_tdata,  // free_address[31:0]
	input  logic [tpsa_pkg::S_TUSER_W-1:0] s_axis_tuser,  // opcode[0], pool_select[1]
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [tpsa_pkg::M_TDATA_W-1:0] m_axis_tdata,  // slot_address[31:0], slot_index[36:32]
	input  logic [tpsa_pkg::M_TUSER_W-1:0] m_axis_tuser,  // status[1:0], slot_pool[2]
	output int unsigned                    fail_count,
	output int unsigned                    pending
);
	import tpsa_pkg::*;

	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		status_t              status;
		logic [ADDR_W-1:0]    addr;
		logic [INDEX_W-1:0]   slot_idx;
		logic                 pool;
	} slot_result_t;

	logic [ADDR_W-1:0]          small_base;
	logic [ADDR_W-1:0]          large_base;
	logic [SMALL_SLOTS_DEF-1:0] small_map;
	logic [LARGE_SLOTS_DEF-1:0] large_map;
	slot_result_t               expected_results[$];
	int unsigned                mismatches = 0;

	// range end is taken in 64 bits so it never wraps
	function automatic logic in_pool_range(input logic [ADDR_W-1:0] a,
			input logic [ADDR_W-1:0] base, input int unsigned slots,
			input int unsigned bytes);
		logic [63:0] last;
		last = {32'd0, base} + 64'(slots - 1) * 64'(bytes);
		return (a >= base) && ({32'd0, a} <= last);
	endfunction

	function automatic slot_result_t serve_request(input logic op, input logic pool,
			input logic [ADDR_W-1:0] a);
		slot_result_t      r;
		logic [63:0]       map;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] off;
		int unsigned       slots;
		int unsigned       bytes;
		int unsigned       k;
		logic              sel;
		logic              hit_small;
		logic              hit_large;
		r = '0;
		r.status = ST_OK;
		hit_small = in_pool_range(a, small_base, SMALL_SLOTS_DEF, SMALL_SLOT_BYTES_DEF);
		hit_large = in_pool_range(a, large_base, LARGE_SLOTS_DEF, LARGE_SLOT_BYTES_DEF);
		// a free picks its pool by address, small first
		if (op == OP_ALLOC)
			sel = pool;
		else
			sel = hit_small ? POOL_SMALL : POOL_LARGE;
		base  = (sel == POOL_SMALL) ? small_base : large_base;
		slots = (sel == POOL_SMALL) ? SMALL_SLOTS_DEF : LARGE_SLOTS_DEF;
		bytes = (sel == POOL_SMALL) ? SMALL_SLOT_BYTES_DEF : LARGE_SLOT_BYTES_DEF;
		map   = (sel == POOL_SMALL) ? 64'(small_map) : 64'(large_map);
		if (op == OP_ALLOC) begin
			k = slots;
			for (int i = slots - 1; i >= 0; i--)
				if (!map[i])
					k = i;
			if (k == slots) begin
				r.status = ST_NOMEM;
			end else begin
				map[k] = 1'b1;
				r.addr = base + ADDR_W'(k * bytes);
				r.slot_idx = INDEX_W'(k);
				r.pool = sel;
			end
		end else if (a == '0 || !(hit_small || hit_large)) begin
			r.status = ST_BADPARAM;
		end else begin
			off = a - base;
			if (off % bytes != 0) begin
				r.status = ST_BADMEM;
			end else begin
				k = off / bytes;
				map[k] = 1'b0;
				r.addr = a;
				r.slot_idx = INDEX_W'(k);
				r.pool = sel;
			end
		end
		if (sel == POOL_SMALL)
			small_map = map[SMALL_SLOTS_DEF-1:0];
		else
			large_map = map[LARGE_SLOTS_DEF-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		slot_result_t want;
		slot_result_t got;
		if (!arst_n) begin
			small_base = SMALL_BASE_RST;
			large_base = LARGE_BASE_RST;
			small_map = '0;
			large_map = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SMALL_BASE)
					small_base = cfg_data;
				else if (cfg_index == REG_LARGE_BASE)
					large_base = cfg_data;
			end
			// compare before queuing, a request never answers in its own cycle
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser[1:0]);
				got.pool = m_axis_tuser[2];
				got.addr = m_axis_tdata[ADDR_W-1:0];
				got.slot_idx = m_axis_tdata[ADDR_W +: INDEX_W];
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("[%0t] unexpected result beat: status %0d addr %h idx %0d pool %0d",
							$realtime, got.status, got.addr, got.slot_idx, got.pool);
				end else begin
					want = expected_results.pop_front();
					if (got.status != want.status || got.addr != want.addr ||
							got.slot_idx != want.slot_idx || got.pool != want.pool) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT)
							$display("[%0t] result mismatch: exp status %0d addr %h idx %0d pool %0d, %s",
								$realtime, want.status, want.addr, want.slot_idx, want.pool,
								$sformatf("got status %0d addr %h idx %0d pool %0d",
									got.status, got.addr, got.slot_idx, got.pool));
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(serve_request(s_axis_tuser[0], s_axis_tuser[1],
					s_axis_tdata));
			pending <= expected_results.size();
		end
		fail_count <= mismatches;
	end

endmodule

// ===== tb/sv/two_pool_slot_allocator_tb.sv =====
`timescale 1ns / 1ps
// two_pool_slot_allocator_tb: clock, reset, pool base writes and request/result traffic
// for the two-pool slot allocator; prediction and comparison sit in the checker
// depends on tpsa_pkg, two_pool_slot_allocator and two_pool_slot_allocator_checker
module two_pool_slot_allocator_tb;
	import tpsa_pkg::*;

	// cycles with no beat, no register write, before the run is called hung
	localparam int unsigned WATCHDOG_LIMIT = 500;
	// random request beats per base setting, and base settings in the run
	localparam int unsigned PHASE_BEATS = 163;
	localparam int unsigned PHASES = 10;
	// the alloc/free mix flips every this many beats so pools fill and drain
	localparam int unsigned MIX_CHUNK = 24;
	localparam int unsigned ALLOC_HEAVY = 75;
	localparam int unsigned FREE_HEAVY = 30;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SMALL_BASE;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // free_address[31:0]
	logic [S_TUSER_W-1:0] s_axis_tuser = '0;   // opcode[0], pool_select[1]
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;        // slot_address[31:0], slot_index[36:32]
	logic [M_TUSER_W-1:0] m_axis_tuser;        // status[1:0], slot_pool[2]

	int unsigned          fail_count;
	int unsigned          pending;
	int unsigned          idle_cycles = 0;
	bit                   src_burst = 1'b0;
	// bases as last written, used to aim free addresses at real slots
	logic [ADDR_W-1:0]    cur_small_base = SMALL_BASE_RST;
	logic [ADDR_W-1:0]    cur_large_base = LARGE_BASE_RST;

	two_pool_slot_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	two_pool_slot_allocator_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: any beat or register write restarts the count
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side: random stall before each beat, with runs of no stall at all
	initial begin : result_sink
		bit          burst;
		int unsigned stall;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				burst = !burst;
			stall = burst ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			// tready is already high here, only tvalid decides the beat
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// one request beat; tvalid stays high into the next beat when no gap is drawn
	task automatic send_req(input logic op, input logic pool, input logic [ADDR_W-1:0] a);
		int unsigned gap;
		if ($urandom_range(0, 29) == 0)
			src_burst = !src_burst;
		gap = src_burst ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= a;
		s_axis_tuser <= {pool, op};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// sender holds off until every predicted result has come back, then a short settle
	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// both bases in back-to-back writes, only ever called with the block idle
	task automatic write_bases(input logic [ADDR_W-1:0] sb, input logic [ADDR_W-1:0] lb);
		cfg_we <= 1'b1;
		cfg_index <= REG_SMALL_BASE;
		cfg_data <= sb;
		@(posedge clk);
		cfg_index <= REG_LARGE_BASE;
		cfg_data <= lb;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_small_base = sb;
		cur_large_base = lb;
	endtask

	// random request: frees mostly hit real slot addresses of either pool, the rest
	// land off-boundary, just past a pool, just below a base, on zero or anywhere
	task automatic send_random_req(input int unsigned alloc_pct);
		logic              op;
		logic              pool;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] a;
		int unsigned       slots;
		int unsigned       bytes;
		int unsigned       kind;
		op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
		pool = 1'($urandom_range(0, 1));
		a = $urandom;
		if (op == OP_FREE) begin
			base = (pool == POOL_LARGE) ? cur_large_base : cur_small_base;
			slots = (pool == POOL_LARGE) ? LARGE_SLOTS_DEF : SMALL_SLOTS_DEF;
			bytes = (pool == POOL_LARGE) ? LARGE_SLOT_BYTES_DEF : SMALL_SLOT_BYTES_DEF;
			kind = $urandom_range(0, 99);
			if (kind < 55)
				a = base + $urandom_range(0, slots - 1) * bytes;
			else if (kind < 70)
				a = base + $urandom_range(0, slots - 1) * bytes + $urandom_range(1, bytes - 1);
			else if (kind < 78)
				a = base + slots * bytes;
			else if (kind < 84)
				a = base - 1;
			else if (kind < 90)
				a = '0;
		end
		send_req(op, pool, a);
	endtask

	initial begin : stimulus
		logic [ADDR_W-1:0] sb;
		logic [ADDR_W-1:0] lb;
		int unsigned       alloc_pct;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at the reset bases: small at 0, large at 0x100000
		// small slot 0 sits at address zero, the address field is ignored on alloc
		send_req(OP_ALLOC, POOL_SMALL, 32'hFFFF_FFFF);
		// so it can never come back: zero is always a bad parameter
		send_req(OP_FREE, POOL_LARGE, 32'h0000_0000);
		// fill the large pool, then one more runs out of memory
		send_req(OP_ALLOC, POOL_LARGE, 32'h0000_0000);
		send_req(OP_ALLOC, POOL_LARGE, 32'h5555_5555);
		send_req(OP_ALLOC, POOL_LARGE, 32'hAAAA_AAAA);
		send_req(OP_ALLOC, POOL_LARGE, 32'h0000_0000);
		send_req(OP_ALLOC, POOL_LARGE, 32'h0000_0000);
		// large slot 1 freed, then freed again while already free
		send_req(OP_FREE, POOL_SMALL, 32'h0011_0000);
		send_req(OP_FREE, POOL_LARGE, 32'h0011_0000);
		// off a slot boundary inside the large range
		send_req(OP_FREE, POOL_LARGE, 32'h0011_0004);
		// one slot past the large range, and the top address
		send_req(OP_FREE, POOL_LARGE, 32'h0014_0000);
		send_req(OP_FREE, POOL_SMALL, 32'hFFFF_FFFF);
		// lowest free large slot is 1 again
		send_req(OP_ALLOC, POOL_LARGE, 32'h0000_0000);
		send_req(OP_ALLOC, POOL_SMALL, 32'h0000_0000);
		// last small slot, its range end, one byte over it and one slot past it
		send_req(OP_FREE, POOL_SMALL, 32'h0001_3000);
		send_req(OP_FREE, POOL_SMALL, 32'h0001_3001);
		send_req(OP_FREE, POOL_SMALL, 32'h0001_4000);
		// pool_select is ignored on free
		send_req(OP_FREE, POOL_LARGE, 32'h0000_1000);
		// just below the large base, outside both ranges
		send_req(OP_FREE, POOL_SMALL, 32'h000F_FFFF);
		send_req(OP_FREE, POOL_SMALL, 32'h0010_0000);

		// random part, one base setting per phase; bitmaps carry across phases
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_results_drained();
			case (ph)
				// same base: small wins wherever the ranges overlap
				0: begin sb = 32'h0001_0000; lb = 32'h0001_0000; end
				// top of the address space: slot addresses wrap, most can't be freed
				1: begin sb = 32'hFFFF_FFFF; lb = 32'hFFFF_FFFF; end
				// both pools start at zero
				2: begin sb = 32'h0000_0000; lb = 32'h0000_0000; end
				3: begin sb = 32'hFFFF_8000; lb = 32'h0000_0000; end
				// large range runs past 2^32
				4: begin sb = 32'h0004_0000; lb = 32'hFFFE_0000; end
				// large slot 0 inside the small range
				5: begin sb = 32'h0000_0000; lb = 32'h0000_8000; end
				8: begin sb = 32'h8000_0000; lb = 32'h7FFF_0000; end
				9: begin sb = SMALL_BASE_RST; lb = LARGE_BASE_RST; end
				default: begin sb = $urandom; lb = $urandom; end
			endcase
			write_bases(sb, lb);
			alloc_pct = ALLOC_HEAVY;
			for (int n = 0; n < PHASE_BEATS; n++) begin
				if (n % MIX_CHUNK == MIX_CHUNK - 1)
					alloc_pct = (alloc_pct == ALLOC_HEAVY) ? FREE_HEAVY : ALLOC_HEAVY;
				// now and then let the pipe run dry mid-phase
				if ($urandom_range(0, 149) == 0)
					wait_results_drained();
				send_random_req(alloc_pct);
			end
		end

		wait_results_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
